@@ rtl/core/mpfde_pkg.sv @@
// ---------------------------------------------------------------------------
// mpfde_pkg - shared types and constants of the page framebuffer draw engine
// Display geometry, command codes, controller states and the command and
// status words that join the controller to the datapath.
// ---------------------------------------------------------------------------
package mpfde_pkg;

   // display geometry
   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int STORE_BYTES    = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8);
   localparam int ADDR_W         = $clog2(STORE_BYTES);
   localparam int COL_W          = $clog2(DISPLAY_WIDTH);

   // coordinates after adding two 9-bit values, and Bresenham error terms
   typedef logic signed [10:0] coord_type;
   typedef logic signed [13:0] err_type;

   typedef enum logic [2:0] {
      MODE_CLEAR = 3'd0,
      MODE_PIXEL = 3'd1,
      MODE_LINE  = 3'd2,
      MODE_RECT  = 3'd3,
      MODE_FILL  = 3'd4,
      MODE_ROUND = 3'd5,
      MODE_READ  = 3'd6,
      MODE_NONE  = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_CLR,
      ST_LN_LOAD,
      ST_LN_PIX,
      ST_LN_WR,
      ST_FL_SETUP,
      ST_FL_CHK,
      ST_FL_PIX,
      ST_FL_WR,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request word
      logic clr_step;   // zero one byte, advance sweep counter
      logic seg_load;   // set up the current line segment
      logic seg_next;   // advance to the next segment
      logic line_step;  // one Bresenham step
      logic fill_init;  // compute clipped fill bounds
      logic fill_step;  // advance the fill scan
      logic pix_wr;     // write back the modified byte
      logic rd_issue;   // read the requested byte
      logic rsp_zero;   // respond with zero
      logic rsp_read;   // respond with the read byte
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic seg_last;
      logic line_end;
      logic pix_vis;
      logic member;
      logic fill_empty;
      logic fill_last;
   } status_type;

endpackage

@@ rtl/core/mpfde_ram.sv @@
// ---------------------------------------------------------------------------
// mpfde_ram - generic single-port RAM
// One address per cycle, write when enabled, read data registered.
// ---------------------------------------------------------------------------
module mpfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/mpfde_datapath.sv @@
// ---------------------------------------------------------------------------
// mpfde_datapath - coordinate walkers, pixel test and framebuffer access
// Holds the request, the Bresenham walker, the clipped fill scan, the
// clear sweep counter, the framebuffer RAM and the response register.
// ---------------------------------------------------------------------------
module mpfde_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mpfde_pkg::cmd_type    cmd,
   output mpfde_pkg::status_type status,
   input  logic [2:0]            req_mode,
   input  logic signed [8:0]     req_x_a,
   input  logic signed [8:0]     req_y_a,
   input  logic signed [8:0]     req_x_b,
   input  logic signed [8:0]     req_y_b,
   input  logic [5:0]            req_radius,
   input  logic                  req_on,
   input  logic [9:0]            req_read_index,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_read_data
);

   localparam mpfde_pkg::coord_type WIDTH_C  = mpfde_pkg::coord_type'(mpfde_pkg::DISPLAY_WIDTH);
   localparam mpfde_pkg::coord_type HEIGHT_C =
      mpfde_pkg::coord_type'(mpfde_pkg::DISPLAY_HEIGHT);
   localparam logic [mpfde_pkg::ADDR_W-1:0] LAST_ADDR =
      mpfde_pkg::ADDR_W'(mpfde_pkg::STORE_BYTES - 1);

   // captured request
   mpfde_pkg::mode_type  mode_ff;
   mpfde_pkg::coord_type xa_ff, ya_ff, xb_ff, yb_ff;
   logic [5:0]           rad_ff;
   logic                 on_ff;
   logic [9:0]           ridx_ff;
   logic [1:0]           seg_ff;

   // walker state
   mpfde_pkg::coord_type cx_ff, cy_ff, ex_ff, ey_ff;
   mpfde_pkg::err_type   ddx_ff, ddy_ff, acc_ff;
   logic                 stx_neg_ff, sty_neg_ff;
   mpfde_pkg::coord_type col_lo_ff, col_hi_ff, row_hi_ff;
   logic [mpfde_pkg::ADDR_W-1:0] clr_cnt_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff;

   // segment endpoints
   mpfde_pkg::coord_type x1, y1, sx, sy, tx, ty;
   always_comb begin
      x1 = xa_ff + xb_ff - 11'sd1;
      y1 = ya_ff + yb_ff - 11'sd1;
      sx = xa_ff;
      sy = ya_ff;
      tx = xa_ff;
      ty = ya_ff;
      case (mode_ff)
         mpfde_pkg::MODE_LINE: begin
            tx = xb_ff;
            ty = yb_ff;
         end
         mpfde_pkg::MODE_RECT: begin
            case (seg_ff)
               2'd0: begin tx = x1; end
               2'd1: begin sy = y1; tx = x1; ty = y1; end
               2'd2: begin ty = y1; end
               default: begin sx = x1; tx = x1; ty = y1; end
            endcase
         end
         default: begin end
      endcase
   end

   // Bresenham setup and step terms
   mpfde_pkg::err_type dxs, dys, twice, acc_next;
   logic step_x, step_y;
   always_comb begin
      dxs      = mpfde_pkg::err_type'(tx) - mpfde_pkg::err_type'(sx);
      dys      = mpfde_pkg::err_type'(ty) - mpfde_pkg::err_type'(sy);
      twice    = acc_ff <<< 1;
      step_x   = (twice >= ddy_ff);
      step_y   = (twice <= ddx_ff);
      acc_next = acc_ff + (step_x ? ddy_ff : '0) + (step_y ? ddx_ff : '0);
   end

   // clipped fill bounds
   mpfde_pkg::coord_type col_lo, col_hi, row_lo, row_hi, xs_sum, ys_sum;
   always_comb begin
      xs_sum = xa_ff + xb_ff;
      ys_sum = ya_ff + yb_ff;
      col_lo = (xa_ff < 11'sd0) ? 11'sd0 : xa_ff;
      row_lo = (ya_ff < 11'sd0) ? 11'sd0 : ya_ff;
      col_hi = (xs_sum > WIDTH_C)  ? WIDTH_C - 11'sd1  : xs_sum - 11'sd1;
      row_hi = (ys_sum > HEIGHT_C) ? HEIGHT_C - 11'sd1 : ys_sum - 11'sd1;
   end

   // rounded-corner membership of the current scan pixel
   mpfde_pkg::coord_type rad_s, ci, ri, cc, rc;
   logic rounded, band;
   logic [5:0]  ex6, ey6;
   logic [12:0] dist2;
   logic [11:0] rad2;
   always_comb begin
      rad_s   = mpfde_pkg::coord_type'({5'd0, rad_ff});
      rounded = (mode_ff == mpfde_pkg::MODE_ROUND) && (rad_ff != 6'd0) &&
                (xb_ff > (rad_s <<< 1)) && (yb_ff > (rad_s <<< 1));
      ci      = cx_ff - xa_ff;
      ri      = cy_ff - ya_ff;
      band    = ((ci >= rad_s) && (ci < xb_ff - rad_s)) ||
                ((ri >= rad_s) && (ri < yb_ff - rad_s));
      cc      = (ci < rad_s) ? ci : xb_ff - 11'sd1 - ci;
      rc      = (ri < rad_s) ? ri : yb_ff - 11'sd1 - ri;
      ex6     = rad_ff - 6'd1 - cc[5:0];
      ey6     = rad_ff - 6'd1 - rc[5:0];
      dist2   = 13'(ex6 * ex6) + 13'(ey6 * ey6);
      rad2    = 12'(rad_ff * rad_ff);
   end

   // pixel address and bit
   logic [mpfde_pkg::ADDR_W-1:0] pix_addr, ram_addr;
   logic [7:0] bit_mask, ram_rdata, ram_wdata;
   logic       ram_we;
   always_comb begin
      pix_addr = mpfde_pkg::ADDR_W'(cx_ff[mpfde_pkg::COL_W-1:0]) +
                 mpfde_pkg::ADDR_W'(mpfde_pkg::ADDR_W'(cy_ff[10:3]) *
                                    mpfde_pkg::ADDR_W'(mpfde_pkg::DISPLAY_WIDTH));
      bit_mask = 8'd1 << cy_ff[2:0];
      ram_addr = pix_addr;
      if (cmd.clr_step) begin
         ram_addr = clr_cnt_ff;
      end else if (cmd.rd_issue) begin
         ram_addr = mpfde_pkg::ADDR_W'(ridx_ff);
      end
      ram_we    = cmd.clr_step || cmd.pix_wr;
      ram_wdata = cmd.clr_step ? 8'd0 :
                  (on_ff ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));
   end

   mpfde_ram #(
      .WIDTH (8),
      .DEPTH (mpfde_pkg::STORE_BYTES)
   ) u_frame (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // status to controller
   always_comb begin
      status.clr_last   = (clr_cnt_ff == LAST_ADDR);
      status.seg_last   = (mode_ff != mpfde_pkg::MODE_RECT) || (seg_ff == 2'd3);
      status.line_end   = (cx_ff == ex_ff) && (cy_ff == ey_ff);
      status.pix_vis    = (cx_ff >= 11'sd0) && (cx_ff < WIDTH_C) &&
                          (cy_ff >= 11'sd0) && (cy_ff < HEIGHT_C);
      status.member     = !rounded || band || ({1'b0, rad2} >= dist2);
      status.fill_empty = (col_lo_ff > col_hi_ff) || (cy_ff > row_hi_ff);
      status.fill_last  = (cx_ff == col_hi_ff) && (cy_ff == row_hi_ff);
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mpfde_pkg::mode_type'(req_mode);
         xa_ff   <= mpfde_pkg::coord_type'(req_x_a);
         ya_ff   <= mpfde_pkg::coord_type'(req_y_a);
         xb_ff   <= mpfde_pkg::coord_type'(req_x_b);
         yb_ff   <= mpfde_pkg::coord_type'(req_y_b);
         rad_ff  <= req_radius;
         on_ff   <= req_on;
         ridx_ff <= req_read_index;
         seg_ff  <= 2'd0;
      end else if (cmd.seg_next) begin
         seg_ff <= seg_ff + 2'd1;
      end
   end

   // walker and scan
   always_ff @(posedge clock) begin
      if (cmd.seg_load) begin
         cx_ff      <= sx;
         cy_ff      <= sy;
         ex_ff      <= tx;
         ey_ff      <= ty;
         ddx_ff     <= (dxs < 14'sd0) ? -dxs : dxs;
         ddy_ff     <= (dys < 14'sd0) ? dys : -dys;
         acc_ff     <= ((dxs < 14'sd0) ? -dxs : dxs) + ((dys < 14'sd0) ? dys : -dys);
         stx_neg_ff <= !(sx < tx);
         sty_neg_ff <= !(sy < ty);
      end else if (cmd.line_step) begin
         acc_ff <= acc_next;
         if (step_x) begin
            cx_ff <= stx_neg_ff ? cx_ff - 11'sd1 : cx_ff + 11'sd1;
         end
         if (step_y) begin
            cy_ff <= sty_neg_ff ? cy_ff - 11'sd1 : cy_ff + 11'sd1;
         end
      end else if (cmd.fill_init) begin
         cx_ff     <= col_lo;
         cy_ff     <= row_lo;
         col_lo_ff <= col_lo;
         col_hi_ff <= col_hi;
         row_hi_ff <= row_hi;
      end else if (cmd.fill_step) begin
         if (cx_ff == col_hi_ff) begin
            cx_ff <= col_lo_ff;
            cy_ff <= cy_ff + 11'sd1;
         end else begin
            cx_ff <= cx_ff + 11'sd1;
         end
      end
   end

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= (clr_cnt_ff == LAST_ADDR) ? '0 : clr_cnt_ff + 1'b1;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_zero || cmd.rsp_read;
      end
      if (cmd.rsp_read && ({1'b0, ridx_ff} < 11'(mpfde_pkg::STORE_BYTES))) begin
         rsp_data_ff <= ram_rdata;
      end else begin
         rsp_data_ff <= 8'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

@@ rtl/core/mpfde_ctrl.sv @@
// ---------------------------------------------------------------------------
// mpfde_ctrl - command sequencer of the draw engine
// Walks each command through its line segments, fill scan, clear sweep
// or read, with a pixel state and a write state for each drawn pixel.
// ---------------------------------------------------------------------------
module mpfde_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            req_mode,
   input  mpfde_pkg::status_type status,
   output mpfde_pkg::cmd_type    cmd,
   output logic                  busy
);

   mpfde_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpfde_pkg::ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpfde_pkg::ST_INIT_CLR: begin
            if (status.clr_last) state_in = mpfde_pkg::ST_IDLE;
         end
         mpfde_pkg::ST_IDLE: begin
            if (start) begin
               case (mpfde_pkg::mode_type'(req_mode))
                  mpfde_pkg::MODE_CLEAR: state_in = mpfde_pkg::ST_CLR;
                  mpfde_pkg::MODE_PIXEL,
                  mpfde_pkg::MODE_LINE,
                  mpfde_pkg::MODE_RECT:  state_in = mpfde_pkg::ST_LN_LOAD;
                  mpfde_pkg::MODE_FILL,
                  mpfde_pkg::MODE_ROUND: state_in = mpfde_pkg::ST_FL_SETUP;
                  mpfde_pkg::MODE_READ:  state_in = mpfde_pkg::ST_RD_ISSUE;
                  default:               state_in = mpfde_pkg::ST_DONE;
               endcase
            end
         end
         mpfde_pkg::ST_CLR: begin
            if (status.clr_last) state_in = mpfde_pkg::ST_DONE;
         end
         mpfde_pkg::ST_LN_LOAD: state_in = mpfde_pkg::ST_LN_PIX;
         mpfde_pkg::ST_LN_PIX, mpfde_pkg::ST_LN_WR: begin
            if (state_ff == mpfde_pkg::ST_LN_PIX && status.pix_vis) begin
               state_in = mpfde_pkg::ST_LN_WR;
            end else if (status.line_end) begin
               state_in = status.seg_last ? mpfde_pkg::ST_DONE : mpfde_pkg::ST_LN_LOAD;
            end else begin
               state_in = mpfde_pkg::ST_LN_PIX;
            end
         end
         mpfde_pkg::ST_FL_SETUP: state_in = mpfde_pkg::ST_FL_CHK;
         mpfde_pkg::ST_FL_CHK: begin
            state_in = status.fill_empty ? mpfde_pkg::ST_DONE : mpfde_pkg::ST_FL_PIX;
         end
         mpfde_pkg::ST_FL_PIX, mpfde_pkg::ST_FL_WR: begin
            if (state_ff == mpfde_pkg::ST_FL_PIX && status.member) begin
               state_in = mpfde_pkg::ST_FL_WR;
            end else if (status.fill_last) begin
               state_in = mpfde_pkg::ST_DONE;
            end else begin
               state_in = mpfde_pkg::ST_FL_PIX;
            end
         end
         mpfde_pkg::ST_RD_ISSUE: state_in = mpfde_pkg::ST_RD_WAIT;
         mpfde_pkg::ST_RD_WAIT:  state_in = mpfde_pkg::ST_IDLE;
         mpfde_pkg::ST_DONE:     state_in = mpfde_pkg::ST_IDLE;
         default:                state_in = mpfde_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != mpfde_pkg::ST_IDLE);
      case (state_ff)
         mpfde_pkg::ST_INIT_CLR, mpfde_pkg::ST_CLR: cmd.clr_step = 1'b1;
         mpfde_pkg::ST_IDLE:    cmd.load     = start;
         mpfde_pkg::ST_LN_LOAD: cmd.seg_load = 1'b1;
         mpfde_pkg::ST_LN_PIX, mpfde_pkg::ST_LN_WR: begin
            cmd.pix_wr = (state_ff == mpfde_pkg::ST_LN_WR);
            if (state_ff == mpfde_pkg::ST_LN_WR || !status.pix_vis) begin
               cmd.line_step = !status.line_end;
               cmd.seg_next  = status.line_end && !status.seg_last;
            end
         end
         mpfde_pkg::ST_FL_SETUP: cmd.fill_init = 1'b1;
         mpfde_pkg::ST_FL_PIX, mpfde_pkg::ST_FL_WR: begin
            cmd.pix_wr = (state_ff == mpfde_pkg::ST_FL_WR);
            if (state_ff == mpfde_pkg::ST_FL_WR || !status.member) begin
               cmd.fill_step = !status.fill_last;
            end
         end
         mpfde_pkg::ST_RD_ISSUE: cmd.rd_issue = 1'b1;
         mpfde_pkg::ST_RD_WAIT:  cmd.rsp_read = 1'b1;
         mpfde_pkg::ST_DONE:     cmd.rsp_zero = 1'b1;
         default: begin end
      endcase
   end

endmodule

@@ rtl/core/mono_page_framebuffer_draw_engine_unit.sv @@
// ---------------------------------------------------------------------------
// mono_page_framebuffer_draw_engine_unit - monochrome page framebuffer drawer
// Clears and draws pixels, lines, outlines and plain or rounded filled boxes
// into a byte-per-8-rows framebuffer, and reads bytes back.
// ---------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; every command
// returns exactly one response word, a one-cycle rsp_valid strobe that the
// receiver must take as it comes. Each drawn pixel is a read-modify-write of
// the single framebuffer RAM port, a pixel state and then a write state; an
// off-screen line step or a rounded-fill pixel outside a corner skips the
// write state. After reset a clearing pass over all STORE_BYTES (1024) bytes
// runs with busy high before the first command is taken.
module mono_page_framebuffer_draw_engine_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_mode,
   input  logic signed [8:0] req_x_a,
   input  logic signed [8:0] req_y_a,
   input  logic signed [8:0] req_x_b,
   input  logic signed [8:0] req_y_b,
   input  logic [5:0]        req_radius,
   input  logic              req_on,
   input  logic [9:0]        req_read_index,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_data
);

   mpfde_pkg::cmd_type    cmd;
   mpfde_pkg::status_type status;

   mpfde_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   mpfde_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_x_a        (req_x_a),
      .req_y_a        (req_y_a),
      .req_x_b        (req_x_b),
      .req_y_b        (req_y_b),
      .req_radius     (req_radius),
      .req_on         (req_on),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data)
   );

   // a response only ends a command in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a command in progress");

   // an accepted command holds the engine busy
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // the response strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held");

   // the unused mode answers right away
   a_unused_mode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == mpfde_pkg::MODE_NONE) |=> ##1 rsp_valid)
      else $error("unused mode not answered");

endmodule
